// ===== design/stage2_page_table_mapper_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stage-2 page table mapper
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef STAGE2_PAGE_TABLE_MAPPER_CORE_DEFINES_SVH
`define STAGE2_PAGE_TABLE_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define S2PTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("s2ptm assertion failed");

// ante holds -> cons holds in the next cycle
`define S2PTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("s2ptm assertion failed");

`else

`define S2PTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define S2PTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/s2ptm_pkg.sv =====
// ---------------------------------------------------------------------------
// s2ptm_pkg
// Types and constants of the stage-2 page table mapper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2ptm_pkg;

	localparam int POOL_PAGES        = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int PAGE_W            = $clog2(POOL_PAGES);
	localparam int FREE_W            = $clog2(POOL_PAGES + 1);
	localparam int DEPTH             = POOL_PAGES * ENTRIES_PER_TABLE;
	localparam int ADDR_W            = PAGE_W + IDX_W;

	// configuration port
	localparam int PADDR_W = 4;
	localparam logic REG_POOL_BASE = 1'b0;  // paddr[3]

	// descriptor bits
	localparam logic [63:0] DESC_VALID = 64'h1;
	localparam logic [63:0] DESC_TABLE = 64'h2;
	localparam logic [63:0] DESC_AF    = 64'h400;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

	localparam logic [1:0] LVL_0        = 2'd0;
	localparam logic [1:0] LVL_1        = 2'd1;
	localparam logic [1:0] LVL_LAST_TBL = 2'd2;

	typedef struct packed {
		logic [47:0] ipa;
		logic [47:0] out_addr;
		logic [63:0] attr_flags;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [63:0] leaf_descriptor;
		logic [1:0]  pages_taken;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_LEAF
	} state_t;

endpackage

// ===== design/stage2_page_table_mapper_core.sv =====
// ---------------------------------------------------------------------------
// stage2_page_table_mapper_core
// Four-level stage-2 table walker and allocator over an on-chip table pool.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy then stays
// high while the walk reads and checks each table level (table memory
// read, then check and optional allocate/write) for levels 0..2 and then
// writes the leaf; a failed allocation ends the walk early. The result
// shows on rsp with done high for exactly one cycle, the first cycle with
// busy low again; it cannot be held off and must be captured then. A new
// request can be taken in that same cycle, but not before, so walks on the
// single-port table memory never overlap.
// After reset the block clears the table memory one entry per cycle, all
// 8192 entries (POOL_PAGES * 512), with busy high; config writes are taken
// throughout.
`timescale 1ns / 1ps
`include "stage2_page_table_mapper_core_defines.svh"

module stage2_page_table_mapper_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  s2ptm_pkg::req_t                  req,
	output logic                             done,
	output s2ptm_pkg::rsp_t                  rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [s2ptm_pkg::PADDR_W-1:0]    paddr,
	input  logic [63:0]                      pwdata,
	output logic [63:0]                      prdata,
	output logic                             pready
);

	s2ptm_pkg::state_t state_q, state_d;

	logic [s2ptm_pkg::ADDR_W-1:0] clr_q;
	logic [1:0]                   lvl_q;
	logic [s2ptm_pkg::PAGE_W-1:0] page_q;
	logic [1:0]                   taken_q;
	logic [s2ptm_pkg::FREE_W-1:0] next_free_q;
	logic [39:0]                  pool_base_q;
	s2ptm_pkg::req_t              req_q;
	logic                         done_q;
	s2ptm_pkg::rsp_t              rsp_q;

	// table memory
	logic [63:0]                  mem [s2ptm_pkg::DEPTH];
	logic                         mem_we;
	logic                         mem_re;
	logic [s2ptm_pkg::ADDR_W-1:0] mem_addr;
	logic [63:0]                  mem_wdata;
	logic [63:0]                  rdata_q;

	logic [s2ptm_pkg::IDX_W-1:0]  idx;
	logic [52:0]                  diff;
	logic                         hit;
	logic                         full;
	logic [28:0]                  desc_page;
	logic [63:0]                  tbl_desc;
	logic [63:0]                  leaf_desc;
	logic                         cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == s2ptm_pkg::REG_POOL_BASE) ? {24'd0, pool_base_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (cfg_wr && (paddr[3] == s2ptm_pkg::REG_POOL_BASE)) begin
			pool_base_q <= pwdata[39:0];
		end
	end

	// ---------------- walk datapath ----------------
	always_comb begin
		case (lvl_q)
			s2ptm_pkg::LVL_0:        idx = req_q.ipa[47:39];
			s2ptm_pkg::LVL_1:        idx = req_q.ipa[38:30];
			s2ptm_pkg::LVL_LAST_TBL: idx = req_q.ipa[29:21];
			default:                 idx = req_q.ipa[20:12];
		endcase
	end

	// stored descriptor decoded against the current pool base
	assign diff = {1'b0, rdata_q[63:12]} - {25'd0, pool_base_q[39:12]};
	assign hit  = (rdata_q[1:0] == 2'b11) && !diff[52]
	              && (diff[51:0] < 52'(s2ptm_pkg::POOL_PAGES));
	assign full = (next_free_q >= s2ptm_pkg::FREE_W'(s2ptm_pkg::POOL_PAGES));

	assign desc_page = {1'b0, pool_base_q[39:12]} + 29'(next_free_q);
	assign tbl_desc  = {23'd0, desc_page, 12'd0} | s2ptm_pkg::DESC_TABLE
	                   | s2ptm_pkg::DESC_VALID;
	assign leaf_desc = {16'd0, req_q.out_addr[47:12], 12'd0} | req_q.attr_flags
	                   | s2ptm_pkg::DESC_AF | s2ptm_pkg::DESC_VALID;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			s2ptm_pkg::ST_CLEAR: begin
				if (clr_q == s2ptm_pkg::ADDR_W'(s2ptm_pkg::DEPTH - 1)) state_d = s2ptm_pkg::ST_IDLE;
			end
			s2ptm_pkg::ST_IDLE: begin
				if (start) state_d = s2ptm_pkg::ST_READ;
			end
			s2ptm_pkg::ST_READ: state_d = s2ptm_pkg::ST_CHECK;
			s2ptm_pkg::ST_CHECK: begin
				if (!hit && full) state_d = s2ptm_pkg::ST_IDLE;
				else if (lvl_q == s2ptm_pkg::LVL_LAST_TBL) state_d = s2ptm_pkg::ST_LEAF;
				else state_d = s2ptm_pkg::ST_READ;
			end
			s2ptm_pkg::ST_LEAF: state_d = s2ptm_pkg::ST_IDLE;
			default: state_d = s2ptm_pkg::ST_CLEAR;
		endcase
	end

	// ---------------- outputs ----------------
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = {page_q, idx};
		mem_wdata = tbl_desc;
		busy      = 1'b1;
		case (state_q)
			s2ptm_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = 64'd0;
			end
			s2ptm_pkg::ST_IDLE: busy = 1'b0;
			s2ptm_pkg::ST_READ: mem_re = 1'b1;
			s2ptm_pkg::ST_CHECK: mem_we = !hit && !full;
			s2ptm_pkg::ST_LEAF: begin
				mem_we    = 1'b1;
				mem_wdata = leaf_desc;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= s2ptm_pkg::ST_CLEAR;
			clr_q       <= '0;
			lvl_q       <= s2ptm_pkg::LVL_0;
			page_q      <= '0;
			taken_q     <= '0;
			next_free_q <= s2ptm_pkg::FREE_W'(1);
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				s2ptm_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				s2ptm_pkg::ST_IDLE: begin
					lvl_q   <= s2ptm_pkg::LVL_0;
					page_q  <= '0;
					taken_q <= '0;
				end
				s2ptm_pkg::ST_CHECK: begin
					if (hit) begin
						page_q <= diff[s2ptm_pkg::PAGE_W-1:0];
						lvl_q  <= lvl_q + 1'b1;
					end else if (full) begin
						done_q <= 1'b1;
					end else begin
						page_q      <= next_free_q[s2ptm_pkg::PAGE_W-1:0];
						next_free_q <= next_free_q + 1'b1;
						taken_q     <= taken_q + 1'b1;
						lvl_q       <= lvl_q + 1'b1;
					end
				end
				s2ptm_pkg::ST_LEAF: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == s2ptm_pkg::ST_IDLE && start) req_q <= req;
		if (state_q == s2ptm_pkg::ST_CHECK && !hit && full) begin
			rsp_q.status          <= s2ptm_pkg::STATUS_OOM;
			rsp_q.leaf_descriptor <= 64'd0;
			rsp_q.pages_taken     <= taken_q;
		end else if (state_q == s2ptm_pkg::ST_LEAF) begin
			rsp_q.status          <= s2ptm_pkg::STATUS_OK;
			rsp_q.leaf_descriptor <= leaf_desc;
			rsp_q.pages_taken     <= taken_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// ---------------- assertions ----------------
	`S2PTM_ASSERT_NEXT(a_leaf_done, clk, arst_n, state_q == s2ptm_pkg::ST_LEAF, done_q && (state_q == s2ptm_pkg::ST_IDLE))
	`S2PTM_ASSERT_IMP(a_oom_zero, clk, arst_n, done_q && (rsp_q.status == s2ptm_pkg::STATUS_OOM), rsp_q.leaf_descriptor == 64'd0)
	`S2PTM_ASSERT_IMP(a_free_bound, clk, arst_n, 1'b1, next_free_q <= s2ptm_pkg::FREE_W'(s2ptm_pkg::POOL_PAGES))
	`S2PTM_ASSERT_IMP(a_no_wr_on_rd, clk, arst_n, mem_re, !mem_we)

endmodule
